### sv/prq_pkg.sv
// Package with the shared types and constants of the priority ready queue.
`default_nettype none
package prq_pkg;

	localparam int CMD_W         = 2;
	localparam int TASK_ID_W     = 6;
	localparam int PRIO_W        = 5;
	localparam int COUNT_W       = 7;
	localparam int DEF_NUM_TASKS  = 64;
	localparam int DEF_NUM_LEVELS = 32;
	localparam int SCAN_GRP      = 8;
	localparam int SCAN_POS_W    = $clog2(SCAN_GRP);

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD    = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_ROTATE = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ADD_HEAD,
		ST_ADD_TAIL,
		ST_ADD_LINK,
		ST_DEL_READ,
		ST_DEL_HEAD,
		ST_ROT_LVL,
		ST_ROT_HEAD,
		ST_ROT_NEXT,
		ST_SCAN_GO,
		ST_SCAN,
		ST_TOP_DONE
	} state_t;

	typedef struct packed {
		logic done;
		logic found;
	} scan_stat_t;

	typedef struct packed {
		logic                 load;
		logic [TASK_ID_W-1:0] top_task;
		logic                 top_valid;
		logic [COUNT_W-1:0]   waiting_count;
		logic                 error;
	} rsp_t;

endpackage
`default_nettype wire

### sv/priority_ready_queue.sv
// Top level of the priority ready queue with the response output register.
// Each command passes through decode, its table steps, the level search and the result step.
// Add to a busy level, delete and rotate add table steps (delete of a level's only task skips
// the head update), and the level search steps over one group of eight levels at a time.
// The command port stays stalled until the result is loaded into the output register.
// Reset clears the control state, queue flags and count; the tables are not cleared.
`default_nettype none
module priority_ready_queue #(
	parameter int NUM_TASKS  = prq_pkg::DEF_NUM_TASKS,
	parameter int NUM_LEVELS = prq_pkg::DEF_NUM_LEVELS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cmd_valid,
	output logic                                   cmd_stall,
	input  wire logic [prq_pkg::CMD_W-1:0]         command,
	input  wire logic [prq_pkg::TASK_ID_W-1:0]     task_id,
	input  wire logic [prq_pkg::PRIO_W-1:0]        priority_req,
	output logic                                   rsp_valid,
	input  wire logic                              rsp_stall,
	output logic      [prq_pkg::TASK_ID_W-1:0]     top_task,
	output logic                                   top_valid,
	output logic      [prq_pkg::COUNT_W-1:0]       waiting_count,
	output logic                                   error
);

	localparam int TW = $clog2(NUM_TASKS);
	localparam int LW = $clog2(NUM_LEVELS);

	logic                     ready;
	logic                     rsp_free;
	logic [NUM_LEVELS-1:0]    nonempty;
	logic                     scan_start;
	prq_pkg::scan_stat_t      scan_stat;
	logic [LW-1:0]            scan_level;
	prq_pkg::rsp_t            rsp;
	logic                     rsp_valid_q;
	logic [prq_pkg::TASK_ID_W-1:0] top_task_q;
	logic                     top_valid_q;
	logic [prq_pkg::COUNT_W-1:0]   count_q;
	logic                     error_q;

	assign rsp_free = !rsp_valid_q || !rsp_stall;

	prq_ctrl #(
		.NUM_TASKS (NUM_TASKS),
		.NUM_LEVELS(NUM_LEVELS),
		.TW        (TW),
		.LW        (LW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.command     (command),
		.task_id     (task_id),
		.priority_req(priority_req),
		.rsp_free    (rsp_free),
		.ready       (ready),
		.nonempty    (nonempty),
		.scan_start  (scan_start),
		.scan_stat   (scan_stat),
		.scan_level  (scan_level),
		.rsp         (rsp)
	);

	prq_scan #(
		.NUM_LEVELS(NUM_LEVELS),
		.LW        (LW)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (scan_start),
		.nonempty(nonempty),
		.stat    (scan_stat),
		.level   (scan_level)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp.load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp.load) begin
			top_task_q  <= rsp.top_task;
			top_valid_q <= rsp.top_valid;
			count_q     <= rsp.waiting_count;
			error_q     <= rsp.error;
		end
	end

	assign cmd_stall     = !ready;
	assign rsp_valid     = rsp_valid_q;
	assign top_task      = top_task_q;
	assign top_valid     = top_valid_q;
	assign waiting_count = count_q;
	assign error         = error_q;

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("Command port not stalled after a transfer.");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (32'(waiting_count) <= NUM_TASKS))
		else $error("Waiting count exceeds the number of tasks.");

	a_top_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (top_valid == (waiting_count != '0)))
		else $error("Top valid disagrees with the waiting count.");

endmodule
`default_nettype wire

### sv/prq_scan.sv
// Iterative search for the lowest non-empty level, one group of levels per cycle.
`default_nettype none
module prq_scan #(
	parameter int NUM_LEVELS = prq_pkg::DEF_NUM_LEVELS,
	parameter int LW         = $clog2(NUM_LEVELS)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [NUM_LEVELS-1:0] nonempty,
	output prq_pkg::scan_stat_t        stat,
	output logic      [LW-1:0]         level
);

	localparam int GRP  = prq_pkg::SCAN_GRP;
	localparam int NGRP = (NUM_LEVELS + GRP - 1) / GRP;
	localparam int PADW = NGRP * GRP;
	localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;

	logic                            busy_q;
	logic [GW-1:0]                   grp_q;
	logic [PADW-1:0]                 pad;
	logic [GRP-1:0]                  bits;
	logic [prq_pkg::SCAN_POS_W-1:0]  pos;
	logic                            hit;
	logic                            last;

	assign pad  = PADW'(nonempty);
	assign bits = pad[grp_q * GRP +: GRP];
	assign hit  = |bits;
	assign last = (32'(grp_q) == NGRP - 1);

	always_comb begin
		pos = '0;
		for (int i = GRP - 1; i >= 0; i--) begin
			if (bits[i]) begin
				pos = prq_pkg::SCAN_POS_W'(i);
			end
		end
	end

	assign level      = LW'({grp_q, pos});
	assign stat.done  = busy_q && (hit || last);
	assign stat.found = hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			grp_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			grp_q  <= '0;
		end else if (busy_q) begin
			if (hit || last) begin
				busy_q <= 1'b0;
			end else begin
				grp_q <= grp_q + GW'(1);
			end
		end
	end

endmodule
`default_nettype wire

### sv/prq_ctrl.sv
// Command sequencer with the task ring tables, level heads and queue flags.
`default_nettype none
module prq_ctrl #(
	parameter int NUM_TASKS  = prq_pkg::DEF_NUM_TASKS,
	parameter int NUM_LEVELS = prq_pkg::DEF_NUM_LEVELS,
	parameter int TW         = $clog2(NUM_TASKS),
	parameter int LW         = $clog2(NUM_LEVELS)
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cmd_valid,
	input  wire logic [prq_pkg::CMD_W-1:0]       command,
	input  wire logic [prq_pkg::TASK_ID_W-1:0]   task_id,
	input  wire logic [prq_pkg::PRIO_W-1:0]      priority_req,
	input  wire logic                            rsp_free,
	output logic                                 ready,
	output logic      [NUM_LEVELS-1:0]           nonempty,
	output logic                                 scan_start,
	input  wire prq_pkg::scan_stat_t             scan_stat,
	input  wire logic [LW-1:0]                   scan_level,
	output prq_pkg::rsp_t                        rsp
);

	localparam int CW = $clog2(NUM_TASKS + 1);

	prq_pkg::state_t state_q, state_d;
	prq_pkg::cmd_t   cmd_q;

	logic [prq_pkg::TASK_ID_W-1:0] tid_q;
	logic [prq_pkg::PRIO_W-1:0]    pri_q;
	logic                          err_q, err_d;
	logic                          found_q;
	logic [NUM_TASKS-1:0]          queued_q;
	logic [NUM_LEVELS-1:0]         nonempty_q;
	logic [CW-1:0]                 cnt_q;
	logic [TW-1:0]                 h_q, nx_q;
	logic [LW-1:0]                 lv_q;

	logic [TW-1:0] next_mem [NUM_TASKS];
	logic [TW-1:0] prev_mem [NUM_TASKS];
	logic [LW-1:0] lvl_mem  [NUM_TASKS];
	logic [TW-1:0] head_mem [NUM_LEVELS];

	logic          next_we, prev_we, lvl_we, head_we;
	logic          next_re, prev_re, lvl_re, head_re;
	logic [TW-1:0] next_waddr, next_wdata, next_raddr, next_rdata;
	logic [TW-1:0] prev_waddr, prev_wdata, prev_raddr, prev_rdata;
	logic [TW-1:0] lvl_waddr, lvl_raddr;
	logic [LW-1:0] lvl_wdata, lvl_rdata;
	logic [LW-1:0] head_waddr, head_raddr;
	logic [TW-1:0] head_wdata, head_rdata;

	logic          accept, id_ok, pri_ok, is_queued, lvl_full;
	logic [TW-1:0] t;
	logic [LW-1:0] pl;
	logic          q_set, q_clr, ne_set, ne_clr, cnt_inc, cnt_dec;
	logic [LW-1:0] ne_idx;
	logic          lv_ld, h_ld, nx_ld, found_ld;

	assign accept    = cmd_valid && (state_q == prq_pkg::ST_IDLE);
	assign ready     = (state_q == prq_pkg::ST_IDLE);
	assign nonempty  = nonempty_q;
	assign t         = TW'(tid_q);
	assign pl        = LW'(pri_q);
	assign id_ok     = (32'(tid_q) < NUM_TASKS);
	assign pri_ok    = (32'(pri_q) < NUM_LEVELS);
	assign is_queued = id_ok ? queued_q[t] : 1'b0;
	assign lvl_full  = pri_ok ? nonempty_q[pl] : 1'b0;

	always_comb begin
		state_d    = state_q;
		err_d      = err_q;
		next_we    = 1'b0;
		prev_we    = 1'b0;
		lvl_we     = 1'b0;
		head_we    = 1'b0;
		next_re    = 1'b0;
		prev_re    = 1'b0;
		lvl_re     = 1'b0;
		head_re    = 1'b0;
		next_waddr = t;
		next_wdata = t;
		next_raddr = t;
		prev_waddr = t;
		prev_wdata = t;
		prev_raddr = t;
		lvl_waddr  = t;
		lvl_wdata  = pl;
		lvl_raddr  = t;
		head_waddr = pl;
		head_wdata = t;
		head_raddr = pl;
		q_set      = 1'b0;
		q_clr      = 1'b0;
		ne_set     = 1'b0;
		ne_clr     = 1'b0;
		ne_idx     = pl;
		cnt_inc    = 1'b0;
		cnt_dec    = 1'b0;
		lv_ld      = 1'b0;
		h_ld       = 1'b0;
		nx_ld      = 1'b0;
		found_ld   = 1'b0;
		scan_start = 1'b0;
		rsp        = '0;
		case (state_q)
			prq_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = prq_pkg::ST_DECODE;
				end
			end
			prq_pkg::ST_DECODE: begin
				err_d   = 1'b0;
				state_d = prq_pkg::ST_SCAN_GO;
				case (cmd_q)
					prq_pkg::CMD_ADD: begin
						if (!id_ok || !pri_ok || is_queued) begin
							err_d = 1'b1;
						end else if (!lvl_full) begin
							next_we = 1'b1;
							prev_we = 1'b1;
							lvl_we  = 1'b1;
							head_we = 1'b1;
							ne_set  = 1'b1;
							q_set   = 1'b1;
							cnt_inc = 1'b1;
						end else begin
							head_re = 1'b1;
							state_d = prq_pkg::ST_ADD_HEAD;
						end
					end
					prq_pkg::CMD_DELETE: begin
						if (!is_queued) begin
							err_d = 1'b1;
						end else begin
							lvl_re  = 1'b1;
							next_re = 1'b1;
							prev_re = 1'b1;
							state_d = prq_pkg::ST_DEL_READ;
						end
					end
					prq_pkg::CMD_ROTATE: begin
						if (!is_queued) begin
							err_d = 1'b1;
						end else begin
							lvl_re  = 1'b1;
							state_d = prq_pkg::ST_ROT_LVL;
						end
					end
					default: begin
					end
				endcase
			end
			prq_pkg::ST_ADD_HEAD: begin
				h_ld       = 1'b1;
				prev_re    = 1'b1;
				prev_raddr = head_rdata;
				state_d    = prq_pkg::ST_ADD_TAIL;
			end
			prq_pkg::ST_ADD_TAIL: begin
				next_we    = 1'b1;
				next_waddr = prev_rdata;
				prev_we    = 1'b1;
				prev_wdata = prev_rdata;
				lvl_we     = 1'b1;
				state_d    = prq_pkg::ST_ADD_LINK;
			end
			prq_pkg::ST_ADD_LINK: begin
				next_we    = 1'b1;
				next_wdata = h_q;
				prev_we    = 1'b1;
				prev_waddr = h_q;
				q_set      = 1'b1;
				cnt_inc    = 1'b1;
				state_d    = prq_pkg::ST_SCAN_GO;
			end
			prq_pkg::ST_DEL_READ: begin
				if (next_rdata == t) begin
					ne_clr  = 1'b1;
					ne_idx  = lvl_rdata;
					q_clr   = 1'b1;
					cnt_dec = 1'b1;
					state_d = prq_pkg::ST_SCAN_GO;
				end else begin
					next_we    = 1'b1;
					next_waddr = prev_rdata;
					next_wdata = next_rdata;
					prev_we    = 1'b1;
					prev_waddr = next_rdata;
					prev_wdata = prev_rdata;
					head_re    = 1'b1;
					head_raddr = lvl_rdata;
					lv_ld      = 1'b1;
					nx_ld      = 1'b1;
					state_d    = prq_pkg::ST_DEL_HEAD;
				end
			end
			prq_pkg::ST_DEL_HEAD: begin
				if (head_rdata == t) begin
					head_we    = 1'b1;
					head_waddr = lv_q;
					head_wdata = nx_q;
				end
				q_clr   = 1'b1;
				cnt_dec = 1'b1;
				state_d = prq_pkg::ST_SCAN_GO;
			end
			prq_pkg::ST_ROT_LVL: begin
				lv_ld      = 1'b1;
				head_re    = 1'b1;
				head_raddr = lvl_rdata;
				state_d    = prq_pkg::ST_ROT_HEAD;
			end
			prq_pkg::ST_ROT_HEAD: begin
				next_re    = 1'b1;
				next_raddr = head_rdata;
				state_d    = prq_pkg::ST_ROT_NEXT;
			end
			prq_pkg::ST_ROT_NEXT: begin
				head_we    = 1'b1;
				head_waddr = lv_q;
				head_wdata = next_rdata;
				state_d    = prq_pkg::ST_SCAN_GO;
			end
			prq_pkg::ST_SCAN_GO: begin
				scan_start = 1'b1;
				state_d    = prq_pkg::ST_SCAN;
			end
			prq_pkg::ST_SCAN: begin
				if (scan_stat.done) begin
					found_ld   = 1'b1;
					head_re    = 1'b1;
					head_raddr = scan_level;
					state_d    = prq_pkg::ST_TOP_DONE;
				end
			end
			prq_pkg::ST_TOP_DONE: begin
				if (rsp_free) begin
					rsp.load          = 1'b1;
					rsp.top_task      = found_q ? prq_pkg::TASK_ID_W'(head_rdata) : '0;
					rsp.top_valid     = found_q;
					rsp.waiting_count = prq_pkg::COUNT_W'(cnt_q);
					rsp.error         = err_q;
					state_d           = prq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = prq_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= prq_pkg::ST_IDLE;
			err_q      <= 1'b0;
			queued_q   <= '0;
			nonempty_q <= '0;
			cnt_q      <= '0;
		end else begin
			state_q <= state_d;
			err_q   <= err_d;
			if (q_set) begin
				queued_q[t] <= 1'b1;
			end
			if (q_clr) begin
				queued_q[t] <= 1'b0;
			end
			if (ne_set) begin
				nonempty_q[ne_idx] <= 1'b1;
			end
			if (ne_clr) begin
				nonempty_q[ne_idx] <= 1'b0;
			end
			if (cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cnt_dec) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= prq_pkg::cmd_t'(command);
			tid_q <= task_id;
			pri_q <= priority_req;
		end
		if (lv_ld) begin
			lv_q <= lvl_rdata;
		end
		if (h_ld) begin
			h_q <= head_rdata;
		end
		if (nx_ld) begin
			nx_q <= next_rdata;
		end
		if (found_ld) begin
			found_q <= scan_stat.found;
		end
	end

	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[next_waddr] <= next_wdata;
		end
		if (next_re) begin
			next_rdata <= next_mem[next_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (prev_we) begin
			prev_mem[prev_waddr] <= prev_wdata;
		end
		if (prev_re) begin
			prev_rdata <= prev_mem[prev_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (lvl_we) begin
			lvl_mem[lvl_waddr] <= lvl_wdata;
		end
		if (lvl_re) begin
			lvl_rdata <= lvl_mem[lvl_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[head_waddr] <= head_wdata;
		end
		if (head_re) begin
			head_rdata <= head_mem[head_raddr];
		end
	end

endmodule
`default_nettype wire
